### sv/drf_pkg.sv
package drf_pkg;

    // reply kinds carried in tuser
    typedef enum logic [2:0] {
        KIND_HANGED_FREE = 3'd0,
        KIND_NOZZLE_OFF  = 3'd1,
        KIND_AMOUNT      = 3'd2,
        KIND_SUPPLY_DONE = 3'd3,
        KIND_CLOSED      = 3'd4,
        KIND_CONFIRM     = 3'd5,
        KIND_TOTALS      = 3'd6,
        KIND_DEFAULT     = 3'd7
    } t_kind;

    localparam int unsigned IDX_W    = 5;
    localparam int unsigned VOLQ_W   = 28;

    localparam logic [7:0] SOF_BYTE      = 8'h2D;
    localparam logic [7:0] CODE_STATUS   = 8'h81;
    localparam logic [7:0] CODE_AMOUNT   = 8'h84;
    localparam logic [7:0] CODE_AMT_SUB  = 8'h8F;
    localparam logic [7:0] CODE_SUPPLY   = 8'h93;
    localparam logic [7:0] CODE_CLOSED   = 8'h85;
    localparam logic [7:0] CODE_TOTALS   = 8'hA0;
    localparam logic [7:0] CODE_CONFIRM  = 8'h0C;
    localparam logic [7:0] STAT_FREE     = 8'h20;
    localparam logic [7:0] STAT_OFF      = 8'h21;
    localparam logic [7:0] BYTE_ONE      = 8'h01;
    localparam logic [7:0] BYTE_TWO      = 8'h02;
    localparam logic [7:0] BYTE_ZERO     = 8'h00;

    localparam logic [15:0] CRC_POLY     = 16'h1021;
    localparam logic [31:0] DIV10_RECIP  = 32'hCCCCCCCD;
    localparam int unsigned DIV10_SHIFT  = 35;

    typedef struct packed {
        t_kind              kind;
        logic [7:0]         addr;
        logic [7:0]         pid;
        logic [7:0]         nbit;
        logic [VOLQ_W-1:0]  vol;
        logic [23:0]        sum;
        logic [15:0]        price;
    } t_req;

    // whole frame length including the two crc bytes; also the length byte
    function automatic logic [IDX_W-1:0] frame_len(input t_kind kind);
        logic [IDX_W-1:0] len;
        case (kind)
            KIND_AMOUNT:      len = IDX_W'(14);
            KIND_SUPPLY_DONE: len = IDX_W'(17);
            KIND_CLOSED:      len = IDX_W'(22);
            KIND_CONFIRM:     len = IDX_W'(7);
            KIND_TOTALS:      len = IDX_W'(11);
            default:          len = IDX_W'(9);
        endcase
        return len;
    endfunction

    // one byte through crc-16/xmodem, msb first
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
        logic [15:0] crc;
        crc = crc_in ^ {data, 8'h00};
        for (int b = 0; b < 8; b++) begin
            if (crc[15]) begin
                crc = {crc[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                crc = {crc[14:0], 1'b0};
            end
        end
        return crc;
    endfunction

endpackage

### sv/drf_body_sel.sv
module drf_body_sel (
    input  drf_pkg::t_req                   i_req,
    input  logic [drf_pkg::IDX_W-1:0]       i_idx,
    output logic [7:0]                      o_byte
);

    logic [7:0] w_len;
    logic [7:0] w_v0, w_v1, w_v2, w_v3;

    assign w_len = 8'(drf_pkg::frame_len(i_req.kind));
    assign w_v0  = i_req.vol[7:0];
    assign w_v1  = i_req.vol[15:8];
    assign w_v2  = i_req.vol[23:16];
    assign w_v3  = 8'(i_req.vol[drf_pkg::VOLQ_W-1:24]);

    always_comb begin
        o_byte = drf_pkg::BYTE_ZERO;
        case (i_idx)
            5'd0: o_byte = drf_pkg::SOF_BYTE;
            5'd1: o_byte = i_req.addr;
            5'd2: o_byte = i_req.pid;
            5'd3: o_byte = w_len;
            default: begin
                case (i_req.kind)
                    drf_pkg::KIND_NOZZLE_OFF: begin
                        case (i_idx)
                            5'd4:    o_byte = drf_pkg::CODE_STATUS;
                            5'd5:    o_byte = drf_pkg::BYTE_ONE | i_req.nbit;
                            default: o_byte = drf_pkg::STAT_OFF;
                        endcase
                    end
                    drf_pkg::KIND_AMOUNT: begin
                        case (i_idx)
                            5'd4:    o_byte = drf_pkg::CODE_AMOUNT;
                            5'd5:    o_byte = i_req.nbit;
                            5'd6:    o_byte = drf_pkg::CODE_AMT_SUB;
                            5'd7:    o_byte = drf_pkg::BYTE_TWO;
                            5'd8:    o_byte = i_req.addr;
                            5'd9:    o_byte = w_v0;
                            5'd10:   o_byte = w_v1;
                            default: o_byte = w_v2;
                        endcase
                    end
                    drf_pkg::KIND_SUPPLY_DONE: begin
                        case (i_idx)
                            5'd4:    o_byte = drf_pkg::CODE_SUPPLY;
                            5'd5:    o_byte = drf_pkg::BYTE_ONE;
                            5'd6:    o_byte = drf_pkg::CODE_STATUS;
                            5'd7:    o_byte = w_v0;
                            5'd8:    o_byte = w_v1;
                            5'd9:    o_byte = w_v2;
                            5'd10:   o_byte = i_req.sum[7:0];
                            5'd11:   o_byte = i_req.sum[15:8];
                            5'd12:   o_byte = i_req.sum[23:16];
                            5'd13:   o_byte = i_req.price[7:0];
                            default: o_byte = i_req.price[15:8];
                        endcase
                    end
                    drf_pkg::KIND_CLOSED: begin
                        case (i_idx)
                            5'd4:    o_byte = drf_pkg::CODE_CLOSED;
                            5'd5:    o_byte = drf_pkg::BYTE_TWO;
                            5'd6:    o_byte = drf_pkg::CODE_STATUS;
                            5'd7:    o_byte = drf_pkg::BYTE_ONE;
                            5'd8:    o_byte = i_req.addr;
                            5'd9:    o_byte = w_v0;
                            5'd10:   o_byte = w_v1;
                            5'd11:   o_byte = w_v2;
                            5'd18:   o_byte = i_req.price[7:0];
                            5'd19:   o_byte = i_req.price[15:8];
                            default: o_byte = drf_pkg::BYTE_ZERO;
                        endcase
                    end
                    drf_pkg::KIND_CONFIRM: begin
                        o_byte = drf_pkg::CODE_CONFIRM;
                    end
                    drf_pkg::KIND_TOTALS: begin
                        case (i_idx)
                            5'd4:    o_byte = drf_pkg::CODE_TOTALS;
                            5'd5:    o_byte = w_v0;
                            5'd6:    o_byte = w_v1;
                            5'd7:    o_byte = w_v2;
                            default: o_byte = w_v3;
                        endcase
                    end
                    default: begin
                        case (i_idx)
                            5'd4:    o_byte = drf_pkg::CODE_STATUS;
                            5'd5:    o_byte = drf_pkg::BYTE_ONE;
                            default: o_byte = drf_pkg::STAT_FREE;
                        endcase
                    end
                endcase
            end
        endcase
    end

endmodule

### sv/dispenser_response_framer_top.sv
// a request passes the request slot and the framer before its first byte
// reaches the output register; one frame byte per cycle while m_axis_tready
// is high, set by the single byte-wide output register; frames are 7-22 bytes
// reset: synchronous, active low; clears the request slot, the framer and the
// output register, payload registers keep their contents
module dispenser_response_framer_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request side
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [7:0] src_addr, [15:8] packet_id, [18:16] nozzle, [49:19] volume_ml,
    // [73:50] sum_cents, [89:74] price_cents, [95:90] zero
    input  logic [95:0] s_axis_tdata,
    // [2:0] op
    input  logic [2:0]  s_axis_tuser,
    // frame side
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] frame_byte
    output logic [7:0]  m_axis_tdata,
    output logic        m_axis_tlast
);

    localparam int unsigned IW = drf_pkg::IDX_W;

    // request slot, filled while the previous frame is still going out
    logic               r_a_vld;
    drf_pkg::t_kind     r_a_kind;
    logic [7:0]         r_a_addr;
    logic [7:0]         r_a_pid;
    logic [2:0]         r_a_noz;
    logic [30:0]        r_a_vol;
    logic [23:0]        r_a_sum;
    logic [15:0]        r_a_price;

    // framer
    logic               r_b_busy;
    drf_pkg::t_req      r_b_req;
    logic [IW-1:0]      r_b_idx;
    logic [15:0]        r_crc;

    // output register
    logic               r_o_vld;
    logic [7:0]         r_o_data;
    logic               r_o_last;

    logic               w_emit;
    logic               w_take;
    logic [IW-1:0]      w_len;
    logic               w_is_body;
    logic               w_is_last;
    logic [7:0]         w_body;
    logic [7:0]         w_byte;
    logic [62:0]        w_prod;
    drf_pkg::t_req      n_b_req;
    logic [15:0]        n_crc;

    drf_body_sel u_body_sel (
        .i_req  (r_b_req),
        .i_idx  (r_b_idx),
        .o_byte (w_body)
    );

    // a new byte moves into the output register whenever it is free or drains
    assign w_emit    = r_b_busy && (!r_o_vld || m_axis_tready);
    assign w_len     = drf_pkg::frame_len(r_b_req.kind);
    assign w_is_body = (r_b_idx < (w_len - IW'(2)));
    assign w_is_last = (r_b_idx == (w_len - IW'(1)));
    // framer picks up the waiting request when idle or on its final byte
    assign w_take    = r_a_vld && (!r_b_busy || (w_emit && w_is_last));

    assign s_axis_tready = !r_a_vld || w_take;

    // crc low byte then high byte after the body
    always_comb begin
        if (w_is_body) begin
            w_byte = w_body;
        end else if (w_is_last) begin
            w_byte = r_crc[15:8];
        end else begin
            w_byte = r_crc[7:0];
        end
    end

    assign n_crc = drf_pkg::crc_byte(r_crc, w_body);

    // volume / 10 as reciprocal multiply, exact for every 31-bit value
    assign w_prod = 63'(r_a_vol) * 63'(drf_pkg::DIV10_RECIP);

    always_comb begin
        // unknown kind falls back to the hanged-free frame
        n_b_req.kind  = (r_a_kind == drf_pkg::KIND_DEFAULT) ? drf_pkg::KIND_HANGED_FREE
                                                            : r_a_kind;
        n_b_req.addr  = r_a_addr;
        n_b_req.pid   = r_a_pid;
        n_b_req.nbit  = 8'h01 << r_a_noz;
        n_b_req.vol   = w_prod[drf_pkg::DIV10_SHIFT +: drf_pkg::VOLQ_W];
        n_b_req.sum   = r_a_sum;
        n_b_req.price = r_a_price;
    end

    // request slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_a_vld <= 1'b1;
        end else if (w_take) begin
            r_a_vld <= 1'b0;
        end
        if (s_axis_tvalid && s_axis_tready) begin
            r_a_kind  <= drf_pkg::t_kind'(s_axis_tuser);
            r_a_addr  <= s_axis_tdata[7:0];
            r_a_pid   <= s_axis_tdata[15:8];
            r_a_noz   <= s_axis_tdata[18:16];
            r_a_vol   <= s_axis_tdata[49:19];
            r_a_sum   <= s_axis_tdata[73:50];
            r_a_price <= s_axis_tdata[89:74];
        end
    end

    // framer: byte index and running crc
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_busy <= 1'b0;
            r_b_idx  <= '0;
            r_crc    <= '0;
        end else if (w_take) begin
            r_b_busy <= 1'b1;
            r_b_idx  <= '0;
            r_crc    <= '0;
        end else if (w_emit) begin
            r_b_busy <= !w_is_last;
            r_b_idx  <= r_b_idx + IW'(1);
            if (w_is_body) begin
                r_crc <= n_crc;
            end
        end
        if (w_take) begin
            r_b_req <= n_b_req;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_vld <= 1'b0;
        end else if (w_emit) begin
            r_o_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_o_vld <= 1'b0;
        end
        if (w_emit) begin
            r_o_data <= w_byte;
            r_o_last <= w_is_last;
        end
    end

    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = r_o_data;
    assign m_axis_tlast  = r_o_last;

    // byte index never runs past the frame
    a_idx_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_b_busy |-> (r_b_idx < w_len))
        else $error("frame index beyond frame length");

    // a frame only ends on its last byte
    a_no_early_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && !w_is_last) |=> r_b_busy)
        else $error("framer went idle mid-frame");

    // a waiting request is never dropped
    a_req_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_vld && !w_take) |=> r_a_vld)
        else $error("pending request lost");

    // every frame opens with the start byte
    a_sof: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && (r_b_idx == '0)) |=> (m_axis_tdata == drf_pkg::SOF_BYTE))
        else $error("frame did not start with start byte");

endmodule

### tb/sv/reply_frame_checker.sv
module reply_frame_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // request channel as seen by the block
    input  logic        i_req_tvalid,
    input  logic        i_req_tready,
    // [7:0] src_addr, [15:8] packet_id, [18:16] nozzle, [49:19] volume_ml,
    // [73:50] sum_cents, [89:74] price_cents, [95:90] zero
    input  logic [95:0] i_req_tdata,
    // [2:0] op
    input  logic [2:0]  i_req_tuser,
    // frame channel
    input  logic        i_frm_tvalid,
    input  logic        i_frm_tready,
    // [7:0] frame_byte
    input  logic [7:0]  i_frm_tdata,
    input  logic        i_frm_tlast,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_beats_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned FRAME_BYTES_MAX = 22;

    typedef struct packed {
        logic [7:0] value;
        logic       last;
    } t_frame_beat;

    // bytes still owed by the block, oldest first
    t_frame_beat pending_frame_bytes[$];

    // one reply under construction
    logic [7:0]  frame_buf [FRAME_BYTES_MAX];
    int unsigned frame_fill;

    function automatic void add_frame_byte(input logic [7:0] value);
        frame_buf[frame_fill] = value;
        frame_fill++;
    endfunction

    // works out the whole reply for one request and queues its bytes
    function automatic void build_reply_frame(
        input drf_pkg::t_kind kind,
        input logic [7:0]     addr,
        input logic [7:0]     pid,
        input logic [2:0]     nozzle,
        input logic [30:0]    vol_ml,
        input logic [23:0]    sum,
        input logic [15:0]    price
    );
        logic [30:0] vol;
        logic [7:0]  nozzle_bit;
        logic [15:0] crc;
        t_frame_beat beat;
        vol        = vol_ml / 31'd10;
        nozzle_bit = 8'h01 << nozzle;
        frame_fill = 0;
        add_frame_byte(drf_pkg::SOF_BYTE);
        add_frame_byte(addr);
        add_frame_byte(pid);
        // length byte, patched once the body is known
        add_frame_byte(drf_pkg::BYTE_ZERO);
        case (kind)
            drf_pkg::KIND_NOZZLE_OFF: begin
                add_frame_byte(drf_pkg::CODE_STATUS);
                add_frame_byte(drf_pkg::BYTE_ONE | nozzle_bit);
                add_frame_byte(drf_pkg::STAT_OFF);
            end
            drf_pkg::KIND_AMOUNT: begin
                add_frame_byte(drf_pkg::CODE_AMOUNT);
                add_frame_byte(nozzle_bit);
                add_frame_byte(drf_pkg::CODE_AMT_SUB);
                add_frame_byte(drf_pkg::BYTE_TWO);
                add_frame_byte(addr);
                add_frame_byte(vol[7:0]);
                add_frame_byte(vol[15:8]);
                add_frame_byte(vol[23:16]);
            end
            drf_pkg::KIND_SUPPLY_DONE: begin
                add_frame_byte(drf_pkg::CODE_SUPPLY);
                add_frame_byte(drf_pkg::BYTE_ONE);
                add_frame_byte(drf_pkg::CODE_STATUS);
                add_frame_byte(vol[7:0]);
                add_frame_byte(vol[15:8]);
                add_frame_byte(vol[23:16]);
                add_frame_byte(sum[7:0]);
                add_frame_byte(sum[15:8]);
                add_frame_byte(sum[23:16]);
                add_frame_byte(price[7:0]);
                add_frame_byte(price[15:8]);
            end
            drf_pkg::KIND_CLOSED: begin
                add_frame_byte(drf_pkg::CODE_CLOSED);
                add_frame_byte(drf_pkg::BYTE_TWO);
                add_frame_byte(drf_pkg::CODE_STATUS);
                add_frame_byte(drf_pkg::BYTE_ONE);
                add_frame_byte(addr);
                add_frame_byte(vol[7:0]);
                add_frame_byte(vol[15:8]);
                add_frame_byte(vol[23:16]);
                for (int k = 0; k < 6; k++) begin
                    add_frame_byte(drf_pkg::BYTE_ZERO);
                end
                add_frame_byte(price[7:0]);
                add_frame_byte(price[15:8]);
            end
            drf_pkg::KIND_CONFIRM: begin
                add_frame_byte(drf_pkg::CODE_CONFIRM);
            end
            drf_pkg::KIND_TOTALS: begin
                add_frame_byte(drf_pkg::CODE_TOTALS);
                add_frame_byte(vol[7:0]);
                add_frame_byte(vol[15:8]);
                add_frame_byte(vol[23:16]);
                add_frame_byte({1'b0, vol[30:24]});
            end
            // hanged free, and the default kind falls back to it
            default: begin
                add_frame_byte(drf_pkg::CODE_STATUS);
                add_frame_byte(drf_pkg::BYTE_ONE);
                add_frame_byte(drf_pkg::STAT_FREE);
            end
        endcase
        // length counts the whole frame, crc included
        frame_buf[3] = 8'(frame_fill + 2);
        crc = '0;
        for (int k = 0; k < int'(frame_fill); k++) begin
            crc = crc ^ {frame_buf[k], 8'h00};
            for (int b = 0; b < 8; b++) begin
                crc = crc[15] ? ((crc << 1) ^ drf_pkg::CRC_POLY) : (crc << 1);
            end
        end
        add_frame_byte(crc[7:0]);
        add_frame_byte(crc[15:8]);
        for (int k = 0; k < int'(frame_fill); k++) begin
            beat.value = frame_buf[k];
            beat.last  = (k == int'(frame_fill) - 1);
            pending_frame_bytes.insert(pending_frame_bytes.size(), beat);
        end
    endfunction

    always @(posedge i_clk) begin
        t_frame_beat want;
        if (i_rst_n) begin
            if (i_req_tvalid && i_req_tready) begin
                build_reply_frame(drf_pkg::t_kind'(i_req_tuser), i_req_tdata[7:0],
                                  i_req_tdata[15:8], i_req_tdata[18:16], i_req_tdata[49:19],
                                  i_req_tdata[73:50], i_req_tdata[89:74]);
            end
            if (i_frm_tvalid && i_frm_tready) begin
                o_beats_checked++;
                if (pending_frame_bytes.size() == 0) begin
                    if (o_fail_count < 10) begin
                        $display("%0t: frame beat %02h last %0b with no reply owed",
                                 $realtime, i_frm_tdata, i_frm_tlast);
                    end
                    o_fail_count++;
                end else begin
                    want = pending_frame_bytes.pop_front();
                    if (want.value !== i_frm_tdata || want.last !== i_frm_tlast) begin
                        if (o_fail_count < 10) begin
                            $display("%0t: frame beat %0d expected %02h last %0b, got %02h last %0b",
                                     $realtime, o_beats_checked, want.value, want.last,
                                     i_frm_tdata, i_frm_tlast);
                        end
                        o_fail_count++;
                    end
                end
            end
            o_pending = pending_frame_bytes.size();
        end
    end

endmodule

### tb/sv/dispenser_response_framer_top_tb.sv
module dispenser_response_framer_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned    RANDOM_REQUESTS = 90;
    localparam int unsigned    HOLD_OFF_BEAT   = 120;
    localparam int unsigned    HOLD_OFF_CYCLES = 400;
    localparam int unsigned    TAIL_CYCLES     = 30;
    localparam int unsigned    CYCLE_LIMIT     = 200000;
    localparam logic [30:0]    VOL_MAX         = 31'h7FFFFFFF;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // [7:0] src_addr, [15:8] packet_id, [18:16] nozzle, [49:19] volume_ml,
    // [73:50] sum_cents, [89:74] price_cents, [95:90] zero
    logic [95:0] s_axis_tdata;
    // [2:0] op
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // [7:0] frame_byte
    logic [7:0]  m_axis_tdata;
    logic        m_axis_tlast;

    int          fail_count;
    int          bytes_owed;
    int          beats_checked;
    int          requests_sent;
    int          beats_taken;
    logic        hold_off;
    logic [7:0]  kinds_seen = '0;

    dispenser_response_framer_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    reply_frame_checker u_frame_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_req_tvalid    (s_axis_tvalid),
        .i_req_tready    (s_axis_tready),
        .i_req_tdata     (s_axis_tdata),
        .i_req_tuser     (s_axis_tuser),
        .i_frm_tvalid    (m_axis_tvalid),
        .i_frm_tready    (m_axis_tready),
        .i_frm_tdata     (m_axis_tdata),
        .i_frm_tlast     (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_pending       (bytes_owed),
        .o_beats_checked (beats_checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // offers one request after a random gap and holds it until taken;
    // every third run of sixteen requests goes back to back
    task automatic send_request(
        input drf_pkg::t_kind kind,
        input logic [7:0]     addr,
        input logic [7:0]     pid,
        input logic [2:0]     nozzle,
        input logic [30:0]    vol_ml,
        input logic [23:0]    sum,
        input logic [15:0]    price
    );
        int gap;
        gap = (((requests_sent / 16) % 3) == 1) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tdata  <= {6'b0, price, sum, vol_ml, nozzle, pid, addr};
        s_axis_tuser  <= kind;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        requests_sent++;
        kinds_seen[kind] = 1'b1;
    endtask

    // one long hold-off on the frame side, timed in cycles, so the
    // request side backs up while requests are still offered
    initial begin
        hold_off <= 1'b0;
        @(posedge i_clk);
        while (beats_taken < HOLD_OFF_BEAT) @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (HOLD_OFF_CYCLES) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // frame side: random stalls per beat, a stall-free stretch now and
    // then, ready kept low while the hold-off lasts
    initial begin
        int stall;
        m_axis_tready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (((beats_taken / 64) % 3) == 2) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 11);
            end
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= !hold_off;
            @(posedge i_clk);
            while (!(m_axis_tvalid && m_axis_tready)) begin
                m_axis_tready <= !hold_off;
                @(posedge i_clk);
            end
            beats_taken++;
        end
    end

    // watchdog
    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("dispenser_response_framer_top verification failed");
        $finish;
    end

    initial begin
        logic [30:0] vol;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= drf_pkg::KIND_HANGED_FREE;
        i_rst_n       <= 1'b0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: every kind, field extremes, ignored fields set high
        send_request(drf_pkg::KIND_HANGED_FREE, 8'h00, 8'h00, 3'd0, '0, '0, '0);
        send_request(drf_pkg::KIND_HANGED_FREE, 8'hFF, 8'hFF, 3'd7, VOL_MAX, 24'hFFFFFF,
                     16'hFFFF);
        send_request(drf_pkg::KIND_NOZZLE_OFF, 8'h01, 8'h80, 3'd0, '0, '0, '0);
        send_request(drf_pkg::KIND_NOZZLE_OFF, 8'hFF, 8'h00, 3'd7, VOL_MAX, 24'hFFFFFF,
                     16'hFFFF);
        send_request(drf_pkg::KIND_AMOUNT, 8'h00, 8'hFF, 3'd0, '0, '0, '0);
        // wide volume: upper quotient byte dropped
        send_request(drf_pkg::KIND_AMOUNT, 8'hFF, 8'h5A, 3'd7, VOL_MAX, 24'hFFFFFF, 16'hFFFF);
        // below ten truncates to zero
        send_request(drf_pkg::KIND_AMOUNT, 8'hA5, 8'h3C, 3'd3, 31'd9, '0, '0);
        send_request(drf_pkg::KIND_AMOUNT, 8'h12, 8'h34, 3'd5, 31'd167772159, '0, '0);
        send_request(drf_pkg::KIND_SUPPLY_DONE, 8'hFF, 8'hFF, 3'd7, VOL_MAX, 24'hFFFFFF,
                     16'hFFFF);
        send_request(drf_pkg::KIND_SUPPLY_DONE, 8'h00, 8'h00, 3'd0, '0, '0, '0);
        send_request(drf_pkg::KIND_SUPPLY_DONE, 8'h55, 8'hAA, 3'd2, 31'd10, 24'd1, 16'd1);
        send_request(drf_pkg::KIND_CLOSED, 8'hFF, 8'h01, 3'd7, VOL_MAX, 24'hFFFFFF, 16'hFFFF);
        send_request(drf_pkg::KIND_CLOSED, 8'h00, 8'hFE, 3'd0, '0, '0, '0);
        send_request(drf_pkg::KIND_CONFIRM, 8'hFF, 8'hFF, 3'd7, VOL_MAX, 24'hFFFFFF, 16'hFFFF);
        send_request(drf_pkg::KIND_CONFIRM, 8'h00, 8'h00, 3'd0, '0, '0, '0);
        send_request(drf_pkg::KIND_TOTALS, 8'hC3, 8'h3C, 3'd1, VOL_MAX, 24'hFFFFFF, 16'hFFFF);
        send_request(drf_pkg::KIND_TOTALS, 8'h00, 8'h00, 3'd0, '0, '0, '0);
        send_request(drf_pkg::KIND_TOTALS, 8'h7E, 8'hE7, 3'd6, 31'd2147483640, '0, '0);
        send_request(drf_pkg::KIND_DEFAULT, 8'h00, 8'h00, 3'd0, '0, '0, '0);
        send_request(drf_pkg::KIND_DEFAULT, 8'hFF, 8'hFF, 3'd7, VOL_MAX, 24'hFFFFFF, 16'hFFFF);

        // random: full-range fields, an eighth of volumes kept small
        for (int k = 0; k < RANDOM_REQUESTS; k++) begin
            case ($urandom_range(0, 7))
                0:       vol = 31'($urandom_range(0, 99999));
                1:       vol = VOL_MAX;
                default: vol = 31'($urandom);
            endcase
            send_request(drf_pkg::t_kind'($urandom_range(0, 7)), 8'($urandom), 8'($urandom),
                         3'($urandom), vol, 24'($urandom), 16'($urandom));
        end
        s_axis_tvalid <= 1'b0;

        // drain, then leave room for any stray beat
        @(posedge i_clk);
        while (bytes_owed != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("covered %0d requests, reply kinds seen %b, %0d frame beats compared",
                 requests_sent, kinds_seen, beats_checked);
        $display("frame side held off once for %0d cycles with requests still offered",
                 HOLD_OFF_CYCLES);
        if (fail_count == 0) begin
            $display("dispenser_response_framer_top verification clean");
        end else begin
            $display("dispenser_response_framer_top verification failed");
        end
        $finish;
    end

endmodule
